>>> rtl/tnwt_pkg.sv
// Shared types and constants for the timed note window table.
// Used by tnwt_ctrl, tnwt_dp and timed_note_window_table; no dependencies.
`timescale 1ns / 1ps

package tnwt_pkg;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_QUERY  = 3'd2;
	localparam logic [2:0] OP_EXPIRE = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam int          MAX_RESULTS  = 16;
	localparam int          CNT_W        = 5;
	localparam logic [19:0] WINDOW_RESET = 20'd100000;
	localparam logic [19:0] WINDOW_MAX   = 20'd1000000;
	localparam logic [19:0] WINDOW_MIN   = 20'd1;

	typedef struct packed {
		logic [2:0]  op;
		logic [6:0]  note;
		logic [31:0] time_us;
		logic [19:0] query_window_us;
		logic [4:0]  max_count;
	} cmd_t;

	typedef struct packed {
		logic [6:0] found_note;
		logic       has_note;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [6:0]  note;
		logic [31:0] time_us;
	} slot_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
		logic clear;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic last_addr;
	} stat_t;

endpackage

>>> rtl/tnwt_ctrl.sv
// Sequencer for the timed note window table: idle, slot scan, drain, finish.
// Depends on tnwt_pkg for the control and status structs and op codes.
`timescale 1ns / 1ps

module tnwt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        op,
	input  tnwt_pkg::stat_t   stat,
	output tnwt_pkg::ctl_t    ctl,
	output logic              busy
);

	typedef enum logic [3:0] {
		IDLE   = 4'b0001,
		SCAN   = 4'b0010,
		DRAIN  = 4'b0100,
		FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   accept;
	logic   scan_op;

	assign busy   = (state_q != IDLE);
	assign accept = start && !busy;

	always_comb begin
		scan_op = op inside {tnwt_pkg::OP_ADD, tnwt_pkg::OP_REMOVE,
			tnwt_pkg::OP_QUERY, tnwt_pkg::OP_EXPIRE};
	end

	always_comb begin
		state_d    = state_q;
		ctl.load   = 1'b0;
		ctl.scan   = 1'b0;
		ctl.finish = 1'b0;
		ctl.clear  = 1'b0;
		case (state_q)
			IDLE: begin
				if (accept) begin
					ctl.load  = 1'b1;
					ctl.clear = (op == tnwt_pkg::OP_CLEAR);
					if (scan_op) state_d = SCAN;
				end
			end
			SCAN: begin
				ctl.scan = 1'b1;
				if (stat.last_addr) state_d = DRAIN;
			end
			DRAIN: begin
				state_d = FINISH;
			end
			FINISH: begin
				ctl.finish = 1'b1;
				state_d    = IDLE;
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= IDLE;
		else state_q <= state_d;
	end

endmodule

>>> rtl/tnwt_dp.sv
// Datapath of the timed note window table: slot memory, active bits, pointer,
// scan tracking and result register. Depends on tnwt_pkg.
`timescale 1ns / 1ps

module tnwt_dp #(
	parameter int SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tnwt_pkg::cmd_t   cmd,
	input  tnwt_pkg::ctl_t   ctl,
	input  logic             cfg_write,
	input  logic [19:0]      cfg_data,
	output tnwt_pkg::stat_t  stat,
	output tnwt_pkg::res_t   result,
	output logic             result_valid
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	tnwt_pkg::slot_t mem [SLOTS];

	logic [SLOTS-1:0]          active_q;
	logic [IDX_W-1:0]          ptr_q;
	logic [IDX_W-1:0]          addr_q;
	logic [19:0]               exp_win_q;

	logic [2:0]                op_q;
	logic [6:0]                note_q;
	logic [31:0]               time_q;
	logic [19:0]               win_q;
	logic [tnwt_pkg::CNT_W-1:0] limit_q;
	logic [tnwt_pkg::CNT_W-1:0] count_q;

	logic                      match_found_q, free_found_q;
	logic [IDX_W-1:0]          match_idx_q, free_idx_q;
	logic                      pend_vld_q;
	logic [6:0]                pend_note_q;

	logic                      rd_vld_s1;
	logic [IDX_W-1:0]          idx_s1;
	tnwt_pkg::slot_t           rd_s1;

	logic                      rd_act, rd_hit, rd_free, rd_old, rd_recent;
	logic [32:0]               sum_exp, sum_qry;
	logic                      take, emit_mid, emit_end;
	logic [IDX_W-1:0]          add_idx;
	logic                      add_fin, use_ptr;

	assign stat.last_addr = (addr_q == LAST_IDX);

	always_comb begin
		rd_act    = rd_vld_s1 && active_q[idx_s1];
		sum_exp   = {1'b0, rd_s1.time_us} + 33'(exp_win_q);
		sum_qry   = {1'b0, rd_s1.time_us} + 33'(win_q);
		rd_hit    = rd_act && (rd_s1.note == note_q);
		rd_free   = rd_vld_s1 && !active_q[idx_s1];
		// older than time minus window; a negative cutoff never matches
		rd_old    = rd_act && (sum_exp < {1'b0, time_q});
		rd_recent = rd_act && (sum_qry >= {1'b0, time_q});
		take      = (op_q == tnwt_pkg::OP_QUERY) && rd_recent && (count_q < limit_q);
		emit_mid  = take && pend_vld_q;
		emit_end  = ctl.finish && (op_q == tnwt_pkg::OP_QUERY);
		add_fin   = ctl.finish && (op_q == tnwt_pkg::OP_ADD);
		use_ptr   = !match_found_q && !free_found_q;
		add_idx   = match_found_q ? match_idx_q : (free_found_q ? free_idx_q : ptr_q);
	end

	// slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (add_fin) mem[add_idx] <= '{note: note_q, time_us: time_q};
		if (ctl.scan) rd_s1 <= mem[addr_q];
	end

	// latched command fields
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q    <= cmd.op;
			note_q  <= cmd.note;
			time_q  <= cmd.time_us;
			win_q   <= cmd.query_window_us;
			limit_q <= (cmd.max_count > tnwt_pkg::CNT_W'(tnwt_pkg::MAX_RESULTS)) ?
				tnwt_pkg::CNT_W'(tnwt_pkg::MAX_RESULTS) : cmd.max_count;
		end
		if (take) pend_note_q <= rd_s1.note;
		if (rd_hit && !match_found_q) match_idx_q <= idx_s1;
		if (rd_free && !free_found_q) free_idx_q <= idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q        <= '0;
			rd_vld_s1     <= 1'b0;
			idx_s1        <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			count_q       <= '0;
			pend_vld_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= ctl.scan;
			idx_s1    <= addr_q;
			if (ctl.load) begin
				addr_q        <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				count_q       <= '0;
				pend_vld_q    <= 1'b0;
			end else begin
				if (ctl.scan) addr_q <= addr_q + 1'b1;
				if (rd_hit) match_found_q <= 1'b1;
				if (rd_free) free_found_q <= 1'b1;
				if (take) begin
					count_q    <= count_q + 1'b1;
					pend_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			ptr_q     <= '0;
			exp_win_q <= tnwt_pkg::WINDOW_RESET;
		end else begin
			if (cfg_write && cfg_data >= tnwt_pkg::WINDOW_MIN &&
				cfg_data <= tnwt_pkg::WINDOW_MAX) exp_win_q <= cfg_data;
			if (ctl.clear) begin
				active_q <= '0;
				ptr_q    <= '0;
			end else begin
				if (op_q == tnwt_pkg::OP_EXPIRE && rd_old) active_q[idx_s1] <= 1'b0;
				if (ctl.finish && op_q == tnwt_pkg::OP_REMOVE && match_found_q)
					active_q[match_idx_q] <= 1'b0;
				if (add_fin) begin
					active_q[add_idx] <= 1'b1;
					if (use_ptr) ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
				end
			end
		end
	end

	// result register: hold one listed note back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= emit_mid || emit_end;
	end

	always_ff @(posedge clk) begin
		if (emit_mid) begin
			result <= '{found_note: pend_note_q, has_note: 1'b1, last: 1'b0};
		end else if (emit_end) begin
			if (pend_vld_q) result <= '{found_note: pend_note_q, has_note: 1'b1, last: 1'b1};
			else result <= '{found_note: 7'd0, has_note: 1'b0, last: 1'b1};
		end
	end

endmodule

>>> rtl/timed_note_window_table.sv
// Top level of the timed note window table: controller plus datapath.
// Depends on tnwt_pkg, tnwt_ctrl and tnwt_dp.
`timescale 1ns / 1ps

// Channel   | Ports                          | Beat taken when
// ----------+--------------------------------+-------------------------------
// command   | start, busy, cmd (cmd_t)       | start high and busy low
// result    | result_valid, result (res_t)   | every cycle result_valid is high
// config    | cfg_write, cfg_data[19:0]      | every cycle cfg_write is high
//
// Add, remove, query and expire walk the slot memory one slot per cycle: busy stays high
// after the command beat through scan, drain of the read register and finish.
// Clear and unused op codes finish in the beat cycle and never raise busy.
// A query emits one to max(1, min(max_count, 16)) beats, at most one per cycle (an empty
// listing gives one marker); its last beat is registered from the finish state.
// Reset drops the active bits and the pointer and reloads the window with 100000; slot
// contents stay unknown until written. The result side cannot stall.

module timed_note_window_table #(
	parameter int SLOTS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  tnwt_pkg::cmd_t  cmd,
	input  logic            cfg_write,
	input  logic [19:0]     cfg_data,
	output tnwt_pkg::res_t  result,
	output logic            result_valid
);

	tnwt_pkg::ctl_t  ctl;
	tnwt_pkg::stat_t stat;

	// sequencing only: accept, scan, drain, finish
	tnwt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (cmd.op),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	// storage, compares and the result register
	tnwt_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.ctl          (ctl),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

	// clear and unused op codes finish in the accept cycle
	a_short_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op != tnwt_pkg::OP_ADD && cmd.op != tnwt_pkg::OP_REMOVE &&
			cmd.op != tnwt_pkg::OP_QUERY && cmd.op != tnwt_pkg::OP_EXPIRE) |=> !busy)
		else $error("short op left the block busy");

	// scanning ops hold busy after the beat
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.op == tnwt_pkg::OP_ADD || cmd.op == tnwt_pkg::OP_REMOVE ||
			cmd.op == tnwt_pkg::OP_QUERY || cmd.op == tnwt_pkg::OP_EXPIRE)) |=> busy)
		else $error("scan op did not raise busy");

	// a query always closes with a last beat
	a_query_last: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op == tnwt_pkg::OP_QUERY) |->
			##(SLOTS + 3) (result_valid && result.last))
		else $error("query did not end with a last beat");

	// the empty marker is always the final beat
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.has_note) |-> (result.last && result.found_note == 7'd0))
		else $error("empty marker without last");

endmodule
